// ===== rtl/core/ial_pkg.sv =====
package ial_pkg;

  // Field widths fixed by the request/response format.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned DEPTH_DEF = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(32);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Read address select relative to the walk pointer.
  typedef enum logic [1:0] {
    RD_CUR  = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_APP_WR,
    S_INS_CHK,
    S_INS_WR,
    S_REM_RD0,
    S_REM_CAP,
    S_REM_CHK,
    S_REM_WR,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e                      op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic [CNT_W-1:0]         count;
  } rsp_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic    load_req;
    logic    set_status;
    status_e status;
    logic    ptr_ld_cnt;
    logic    ptr_ld_pos;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_sel_val;
    logic    save_rm;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic pos_bad;
    logic ptr_at_pos;
    logic ptr_last;
    logic rsp_busy;
  } sts_t;

endpackage

// ===== rtl/core/indexed_array_list.sv =====
// Ordered list of signed 32-bit words with insert-at-position, append and
// remove-at-position requests. Each request returns one response carrying a
// status (ok, full, empty, bad position), the removed word (zero unless a
// remove succeeded) and the entry count after the request. The list limit is
// the smallest of the capacity register, DEPTH and 63; lowering capacity below
// the current count keeps the entries, blocks insert/append, allows remove.
// Insert only targets an occupied slot, so it cannot add at the tail.
// One request is in work at a time. Entries live in a single-port-style
// memory (one write, one registered read per cycle), so each entry moved
// takes a read and then a write, and that shift loop sets how soon the next
// request can be accepted. With n the count before the request and p the
// position, a failed or reserved request only decides and finishes; append
// writes at the tail; insert moves the n - p entries from p up one slot and
// writes at p; remove reads and keeps the word at p, then moves the
// n - 1 - p entries above it down one slot. A finished result is held until
// the previous response has been taken with rsp_ready_i. The response sits
// in an output register, so a new request is taken while the previous
// response still waits.
// The capacity register may be written only while no request is in flight.
// The memory needs no clear: only occupied slots are ever read.
module indexed_array_list import ial_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  // response channel
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_o,
  // capacity register write
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: decides each request and walks the shift loop.
  ial_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, count, capacity, walk pointer and response register.
  ial_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_ready_i (rsp_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // One request at a time: after a request is taken, ready drops.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("request accepted while another is in work");

  // An empty status always reports a zero count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_EMPTY) |-> (rsp_o.count == '0))
    else $error("empty status with nonzero count");

  // Only a good response may carry a removed word.
  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_OK) |-> (rsp_o.removed_value == '0))
    else $error("failed request returned a removed word");

  // Count never grows past the storage depth.
  a_count_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (int'(rsp_o.count) <= int'(DEPTH)))
    else $error("count exceeds storage depth");

  // Count never moves both ways in one cycle.
  a_cnt_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.cnt_inc && cmd.cnt_dec))
    else $error("count increment and decrement together");

endmodule

// ===== rtl/core/ial_dpath.sv =====
module ial_dpath import ial_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  req_t             req_i,
  input  logic             rsp_ready_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             rsp_valid_o,
  output rsp_t             rsp_o
);

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned PW      = (AW > CNT_W) ? AW : CNT_W;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned LIM_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  req_t              req_q;
  status_e           status_q;
  logic [DATA_W-1:0] removed_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  cap_q;
  logic [PW-1:0]     ptr_q, ptr_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q;

  logic [CNT_W-1:0]  lim;
  logic [PW-1:0]     ptr_m1, ptr_p1, rd_ptr;
  logic [DATA_W-1:0] wdata;

  assign lim    = (cap_q > CNT_W'(LIM_MAX)) ? CNT_W'(LIM_MAX) : cap_q;
  assign ptr_m1 = ptr_q - PW'(1);
  assign ptr_p1 = ptr_q + PW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PREV: rd_ptr = ptr_m1;
      RD_NEXT: rd_ptr = ptr_p1;
      default: rd_ptr = ptr_q;
    endcase
  end

  assign wdata = cmd_i.wr_sel_val ? req_q.value : rdata_q;

  // Storage: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[ptr_q[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_ptr[AW-1:0]];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    priority if (cmd_i.ptr_ld_cnt) begin
      ptr_d = PW'(cnt_q);
    end else if (cmd_i.ptr_ld_pos) begin
      ptr_d = PW'(req_q.position);
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_p1;
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_m1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign rsp_valid_d = cmd_i.res_load ? 1'b1 : (rsp_ready_i ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      ptr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q     <= req_i;
      status_q  <= ST_OK;
      removed_q <= '0;
    end else begin
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.save_rm) begin
        removed_q <= rdata_q;
      end
    end
    if (cmd_i.res_load) begin
      rsp_q.status        <= status_q;
      rsp_q.removed_value <= removed_q;
      rsp_q.count         <= cnt_q;
    end
  end

  assign sts_o.op         = req_q.op;
  assign sts_o.full       = (cnt_q >= lim);
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.pos_bad    = (CNT_W'(req_q.position) >= cnt_q);
  assign sts_o.ptr_at_pos = (ptr_q == PW'(req_q.position));
  assign sts_o.ptr_last   = (ptr_p1 == PW'(cnt_q));
  assign sts_o.rsp_busy   = rsp_valid_q && !rsp_ready_i;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/core/ial_ctrl.sv =====
module ial_ctrl import ial_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
              state_d          = S_FIN;
            end else if (sts_i.pos_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BADPOS;
              state_d          = S_FIN;
            end else begin
              cmd_o.ptr_ld_cnt = 1'b1;
              state_d          = S_INS_CHK;
            end
          end
          OP_APPEND: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
              state_d          = S_FIN;
            end else begin
              cmd_o.ptr_ld_cnt = 1'b1;
              state_d          = S_APP_WR;
            end
          end
          OP_REMOVE: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
              state_d          = S_FIN;
            end else if (sts_i.pos_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BADPOS;
              state_d          = S_FIN;
            end else begin
              cmd_o.ptr_ld_pos = 1'b1;
              state_d          = S_REM_RD0;
            end
          end
          OP_RSVD: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_APP_WR: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_sel_val = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        state_d          = S_FIN;
      end
      // walk down from the tail, moving each entry up one slot
      S_INS_CHK: begin
        if (sts_i.ptr_at_pos) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel_val = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_dec = 1'b1;
        state_d       = S_INS_CHK;
      end
      S_REM_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CUR;
        state_d      = S_REM_CAP;
      end
      S_REM_CAP: begin
        cmd_o.save_rm = 1'b1;
        state_d       = S_REM_CHK;
      end
      // walk up from the hole, moving each entry down one slot
      S_REM_CHK: begin
        if (sts_i.ptr_last) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_REM_CHK;
      end
      S_FIN: begin
        if (!sts_i.rsp_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
